// ===== rtl/windowed_average_min_max_tracker_macros.svh =====
// Assertion macros used by the RTL.
`ifndef WINDOWED_AVERAGE_MIN_MAX_TRACKER_MACROS_SVH
`define WINDOWED_AVERAGE_MIN_MAX_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define WAMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define WAMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define WAMM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WAMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/wamm_pkg.sv =====
`default_nettype none
package wamm_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WIN_CFG_W       = 7;
  localparam int WINDOW_FLOOR    = 2;
  localparam int WINDOW_DEFAULT  = 60;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUB,
    ST_WRITE,
    ST_DSTART,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic mem_we;
    logic drop;
    logic store;
    logic div_start;
    logic out_load;
  } wamm_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/wamm_if.sv =====
`default_nettype none
interface wamm_in_if import wamm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [0:0]             op;
  logic [SAMPLE_BITS-1:0] speed;

  modport source (output valid, output op, output speed, input ready);
  modport sink   (input valid, input op, input speed, output ready);
endinterface

interface wamm_out_if import wamm_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] current_speed;
  logic [SAMPLE_BITS-1:0] max_speed;
  logic [SAMPLE_BITS-1:0] min_speed;
  logic [SAMPLE_BITS-1:0] mean_speed;

  modport source (output valid, output current_speed, output max_speed,
                  output min_speed, output mean_speed, input ready);
  modport sink   (input valid, input current_speed, input max_speed,
                  input min_speed, input mean_speed, output ready);
endinterface

interface wamm_cfg_if import wamm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [WIN_CFG_W-1:0] window_length;

  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/wamm_ram.sv =====
`default_nettype none
module wamm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/wamm_div.sv =====
`default_nettype none
module wamm_div import wamm_pkg::*; #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic                  done,
  output logic      [NUM_W-1:0] quo
);

  localparam int IT_W = $clog2(NUM_W);
  localparam logic [IT_W-1:0] IT_LAST = IT_W'(NUM_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [IT_W-1:0]  it_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W:0]   shift;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shift = {rem_r, q_r[NUM_W-1]};
  assign diff  = shift - {1'b0, den_r};
  assign ge    = !diff[DEN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      it_r   <= '0;
    end else if (busy_r) begin
      if (it_r == IT_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        it_r <= it_r + 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      q_r   <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : shift[DEN_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;

endmodule
`default_nettype wire

// ===== rtl/windowed_average_min_max_tracker.sv =====
// Windowed average and min/max tracker for speed samples.
// in_bus: one word carries op (0 = sample, 1 = clear history) and speed.
// out_bus: one word per input word with current, max, min and mean speed.
// cfg_bus: writes window_length (clamped to 2..MAX_WINDOW); accepted only
//   while the block is idle.
// Each input word goes from acceptance through ST_CHECK, one ST_SUB and
// ST_CHECK pass for every oldest entry dropped, then ST_WRITE, ST_DSTART,
// ST_DIV and ST_DONE to the result register. Entries are dropped one per
// word once the window is full, and the surplus left by a lowered window at
// the next word. The mean comes from a serial divider, one quotient bit per
// cycle; one word is in flight at a time and in_bus.ready is high only in
// idle, so no word is accepted until the previous result has been loaded.
// The result register holds a finished word while out_bus.ready is low, and
// the next input word is accepted meanwhile; its result waits until the
// register frees up.
// Reset (rst_n low, synchronous) empties the history, clears min, max and
// current speed, and sets window_length to 60. The sample store itself is
// not cleared; only written entries are ever read.
`default_nettype none
`include "windowed_average_min_max_tracker_macros.svh"
module windowed_average_min_max_tracker import wamm_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  wamm_in_if.sink    in_bus,
  wamm_out_if.source out_bus,
  wamm_cfg_if.sink   cfg_bus
);

  localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W    = $clog2(MAX_WINDOW);
  localparam int SUM_W    = SAMPLE_BITS + PTR_W;
  localparam int WL_RESET = (WINDOW_DEFAULT > MAX_WINDOW) ? MAX_WINDOW : WINDOW_DEFAULT;
  localparam logic [CNT_W:0]   MAXW_X  = (CNT_W + 1)'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] MAXW_C  = CNT_W'(MAX_WINDOW);
  localparam logic [PTR_W-1:0] PTR_TOP = PTR_W'(MAX_WINDOW - 1);

  state_t                 st_r, st_nxt;
  wamm_ctl_t              ctl;
  logic [PTR_W-1:0]       wp_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       wl_r, wl_nxt;
  logic [CNT_W-1:0]       trim_r;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] last_r, hi_r, lo_r, smp_r;
  logic [SAMPLE_BITS-1:0] cur_r, max_r, min_r, mean_r;
  logic                   out_valid_r;
  logic                   in_acc, cfg_acc, out_free, is_clear, seed, drop_need;
  logic [SAMPLE_BITS-1:0] s_in;
  logic [CNT_W:0]         wp_x, old_x;
  logic [PTR_W-1:0]       old_idx;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic                   div_busy, div_done;
  logic [SUM_W-1:0]       quo;

  assign in_bus.ready  = (st_r == ST_IDLE);
  assign cfg_bus.ready = (st_r == ST_IDLE);
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign cfg_acc       = cfg_bus.valid && cfg_bus.ready;
  assign out_free      = !out_valid_r || out_bus.ready;
  assign is_clear      = (op_t'(in_bus.op) == OP_CLEAR);
  assign s_in          = is_clear ? last_r : in_bus.speed;
  assign seed          = is_clear || (cnt_r == '0);
  assign drop_need     = (cnt_r != '0) && ((cnt_r >= wl_r) || (cnt_r > trim_r));

  assign wp_x    = (CNT_W + 1)'(wp_r);
  assign old_x   = (wp_x >= {1'b0, cnt_r}) ? (wp_x - {1'b0, cnt_r})
                                           : (wp_x + MAXW_X - {1'b0, cnt_r});
  assign old_idx = old_x[PTR_W-1:0];

  always_comb begin
    logic [31:0] wv;
    wv = 32'(cfg_bus.window_length);
    if (wv < 32'(WINDOW_FLOOR)) begin
      wv = 32'(WINDOW_FLOOR);
    end
    if (wv > 32'(MAX_WINDOW)) begin
      wv = 32'(MAX_WINDOW);
    end
    wl_nxt = wv[CNT_W-1:0];
  end

  // shared add/subtract for the running sum
  assign sum_nxt = ctl.drop ? (sum_r - SUM_W'(rd_data)) : (sum_r + SUM_W'(smp_r));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_acc) st_nxt = ST_CHECK;
      ST_CHECK:  st_nxt = drop_need ? ST_SUB : ST_WRITE;
      ST_SUB:    st_nxt = ST_CHECK;
      ST_WRITE:  st_nxt = ST_DSTART;
      ST_DSTART: st_nxt = ST_DIV;
      ST_DIV:    if (div_done) st_nxt = ST_DONE;
      ST_DONE:   if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (st_r)
      ST_SUB: begin
        ctl.drop = 1'b1;
      end
      ST_WRITE: begin
        ctl.mem_we = 1'b1;
        ctl.store  = 1'b1;
      end
      ST_DSTART: begin
        ctl.div_start = 1'b1;
      end
      ST_DONE: begin
        ctl.out_load = out_free;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wp_r        <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      last_r      <= '0;
      hi_r        <= '0;
      lo_r        <= '0;
      wl_r        <= CNT_W'(WL_RESET);
      trim_r      <= MAXW_C;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_acc) begin
        wl_r <= wl_nxt;
        if (wl_nxt < trim_r) begin
          trim_r <= wl_nxt;
        end
      end
      if (in_acc) begin
        last_r <= s_in;
        hi_r   <= (seed || (s_in > hi_r)) ? s_in : hi_r;
        lo_r   <= (seed || (s_in < lo_r)) ? s_in : lo_r;
        if (is_clear) begin
          cnt_r <= '0;
          sum_r <= '0;
        end
      end
      if (ctl.drop) begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_r - 1'b1;
      end
      if (ctl.store) begin
        sum_r  <= sum_nxt;
        cnt_r  <= cnt_r + 1'b1;
        wp_r   <= (wp_r == PTR_TOP) ? '0 : (wp_r + 1'b1);
        trim_r <= MAXW_C;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r <= s_in;
    end
    if (ctl.out_load) begin
      cur_r  <= last_r;
      max_r  <= hi_r;
      min_r  <= lo_r;
      mean_r <= quo[SAMPLE_BITS-1:0];
    end
  end

  wamm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ctl.mem_we),
    .waddr (wp_r),
    .wdata (smp_r),
    .raddr (old_idx),
    .rdata (rd_data)
  );

  wamm_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (sum_r),
    .den   (cnt_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  assign out_bus.valid         = out_valid_r;
  assign out_bus.current_speed = cur_r;
  assign out_bus.max_speed     = max_r;
  assign out_bus.min_speed     = min_r;
  assign out_bus.mean_speed    = mean_r;

  `WAMM_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= MAXW_C)
  `WAMM_ASSERT_IMP(a_peak_order, clk, rst_n, 1'b1, lo_r <= hi_r)
  `WAMM_ASSERT_IMP(a_div_in_div, clk, rst_n, st_r == ST_DIV && !div_done, div_busy)
  `WAMM_ASSERT_IMP(a_done_nonempty, clk, rst_n, st_r == ST_DONE, cnt_r != '0)
  `WAMM_ASSERT_NXT(a_load_valid, clk, rst_n, ctl.out_load, out_valid_r)

endmodule
`default_nettype wire

// ===== bench/tb_windowed_average_min_max_tracker.sv =====
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] current;
  logic [15:0] peak_max;
  logic [15:0] peak_min;
  logic [15:0] mean;
} speed_report_t;

class speed_tracker_scoreboard;
  logic [15:0]   history[wamm_pkg::MAX_WINDOW_DEF];
  bit [5:0]      head;
  int unsigned   count;
  bit [21:0]     sum;
  logic [15:0]   latest;
  logic [15:0]   peak_max;
  logic [15:0]   peak_min;
  int unsigned   window;
  speed_report_t reports[$];
  int unsigned   errors;

  function new();
    head     = '0;
    count    = 0;
    sum      = '0;
    latest   = '0;
    peak_max = '0;
    peak_min = '0;
    window   = wamm_pkg::WINDOW_DEFAULT;
    errors   = 0;
    foreach (history[i]) history[i] = '0;
  endfunction

  function void drop_oldest();
    bit [5:0] idx;
    idx = head - 6'(count);
    sum -= 22'(history[idx]);
    count--;
  endfunction

  function void set_window(logic [6:0] value);
    int unsigned w;
    w = value;
    if (w < wamm_pkg::WINDOW_FLOOR) w = wamm_pkg::WINDOW_FLOOR;
    if (w > wamm_pkg::MAX_WINDOW_DEF) w = wamm_pkg::MAX_WINDOW_DEF;
    window = w;
    while (count > window) drop_oldest();
  endfunction

  function void take_sample(logic [15:0] s);
    latest = s;
    if (count == 0) begin
      peak_max = s;
      peak_min = s;
    end else begin
      if (s > peak_max) peak_max = s;
      if (s < peak_min) peak_min = s;
    end
    while (count >= window && count > 0) drop_oldest();
    history[head] = s;
    head++;
    count++;
    sum += 22'(s);
  endfunction

  function void note_word(wamm_pkg::op_t op, logic [15:0] speed);
    speed_report_t r;
    if (op == wamm_pkg::OP_CLEAR) begin
      count = 0;
      sum   = '0;
      take_sample(latest);
    end else begin
      take_sample(speed);
    end
    r.current  = latest;
    r.peak_max = peak_max;
    r.peak_min = peak_min;
    r.mean     = (count != 0) ? 16'(sum / 22'(count)) : '0;
    reports.push_back(r);
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endfunction

  function void check_report(speed_report_t got);
    speed_report_t want;
    if (reports.size() == 0) begin
      errors++;
      $error("result word with no report pending");
      return;
    end
    want = reports.pop_front();
    compare_field("current_speed", want.current, got.current);
    compare_field("max_speed", want.peak_max, got.peak_max);
    compare_field("min_speed", want.peak_min, got.peak_min);
    compare_field("mean_speed", want.mean, got.mean);
  endfunction

  function int pending();
    return reports.size();
  endfunction
endclass

module tb_windowed_average_min_max_tracker;
  import wamm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 9;
  localparam int PHASE_WORDS    = 115;

  typedef enum {SPD_ANY, SPD_EDGE, SPD_NARROW, SPD_FULL_SCALE} speed_mix_t;

  logic        clk;
  logic        rst_n;
  int unsigned idle_cycles;
  bit          steady;

  speed_tracker_scoreboard sb;

  wamm_in_if  in_bus ();
  wamm_out_if out_bus ();
  wamm_cfg_if cfg_bus ();

  windowed_average_min_max_tracker dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) sb.set_window(cfg_bus.window_length);
      if (out_bus.valid && out_bus.ready) begin
        sb.check_report({out_bus.current_speed, out_bus.max_speed,
                         out_bus.min_speed, out_bus.mean_speed});
      end
      if (in_bus.valid && in_bus.ready) sb.note_word(op_t'(in_bus.op), in_bus.speed);
      if ((cfg_bus.valid && cfg_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (in_bus.valid && in_bus.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_speed(speed_mix_t mix);
    case (mix)
      SPD_EDGE: begin
        case ($urandom_range(0, 5))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'h7FFF;
          3: return 16'h8000;
          4: return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
      SPD_NARROW: return 16'($urandom_range(1000, 1100));
      SPD_FULL_SCALE: return ($urandom_range(0, 19) == 0) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // call at a falling edge; leaves valid high for back-to-back words
  task automatic send_word(op_t op, logic [15:0] speed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.op    = op;
    in_bus.speed = speed;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_reports();
    in_bus.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_window(logic [6:0] value);
    cfg_bus.valid         = 1'b1;
    cfg_bus.window_length = value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  initial begin
    int n;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_bus.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    logic [6:0] presets[7];
    speed_mix_t mix;
    op_t        op;
    int         clear_pct;

    presets = '{7'd127, 7'd2, 7'd65, 7'd60, 7'd3, 7'd64, 7'd1};
    sb = new();
    rst_n                 = 1'b0;
    steady                = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.op             = OP_SAMPLE;
    in_bus.speed          = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.window_length = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // clear before any sample, field extremes, clear with a stale speed
    send_word(OP_CLEAR, 16'h0000);
    send_word(OP_SAMPLE, 16'h0000);
    send_word(OP_SAMPLE, 16'hFFFF);
    send_word(OP_SAMPLE, 16'h0001);
    send_word(OP_SAMPLE, 16'h8000);
    send_word(OP_SAMPLE, 16'h7FFF);
    send_word(OP_CLEAR, 16'hFFFF);
    send_word(OP_SAMPLE, 16'h5555);
    send_word(OP_SAMPLE, 16'hAAAA);

    // lower then raise the window with no word in between
    wait_for_reports();
    write_window(7'd3);
    write_window(7'd64);
    send_word(OP_SAMPLE, 16'h0F0F);

    // short window: lower with entries stored, then overrun it
    wait_for_reports();
    write_window(7'd0);
    send_word(OP_SAMPLE, 16'h1234);
    send_word(OP_SAMPLE, 16'hFFFF);
    send_word(OP_SAMPLE, 16'h0000);
    wait_for_reports();
    write_window(7'd1);
    send_word(OP_SAMPLE, 16'hFFFF);
    send_word(OP_CLEAR, 16'h0000);
    send_word(OP_SAMPLE, 16'hFFFE);

    for (int p = 0; p < PHASES; p++) begin
      wait_for_reports();
      write_window(p < 7 ? presets[p] : 7'($urandom_range(0, 127)));
      mix       = (p == 0) ? SPD_FULL_SCALE : speed_mix_t'($urandom_range(0, 3));
      clear_pct = (p % 2 == 0) ? 1 : 6;
      steady    = (p % 3 == 1);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // hold the sender until the block drains
        if (p % 2 == 0 && n == PHASE_WORDS / 2) wait_for_reports();
        op = ($urandom_range(0, 99) < clear_pct) ? OP_CLEAR : OP_SAMPLE;
        send_word(op, pick_speed(mix));
      end
    end

    wait_for_reports();
    repeat (64) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
